>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the RTL. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`else

`define ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> design/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types and fixed constants of the SHA-1 digest core.
// ----------------------------------------------------------------------------
package sha1md_pkg;

	typedef logic [31:0] word_t;
	typedef logic [2:0]  byte_count_t;

	// Number of bytes in a full message word.
	localparam byte_count_t FULL_COUNT = 3'd4;

	// Initial chaining values.
	localparam word_t INIT_H0 = 32'h67452301;
	localparam word_t INIT_H1 = 32'hEFCDAB89;
	localparam word_t INIT_H2 = 32'h98BADCFE;
	localparam word_t INIT_H3 = 32'h10325476;
	localparam word_t INIT_H4 = 32'hC3D2E1F0;

	// Round constants, one per group of twenty rounds.
	localparam word_t K_ROUND0 = 32'h5A827999;
	localparam word_t K_ROUND1 = 32'h6ED9EBA1;
	localparam word_t K_ROUND2 = 32'h8F1BBCDC;
	localparam word_t K_ROUND3 = 32'hCA62C1D6;

	// Pad marker byte.
	localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

>>> design/sha1md_ifs.sv
// ----------------------------------------------------------------------------
// sha1md_ifs
// Valid/ready channels of the SHA-1 digest core: message words in, digests out.
// ----------------------------------------------------------------------------
interface sha1md_in_if;
	import sha1md_pkg::*;

	logic        valid;
	logic        ready;
	word_t       data_word;
	byte_count_t byte_count;
	logic        last;

	modport source (output valid, output data_word, output byte_count, output last,
		input ready);
	modport sink (input valid, input data_word, input byte_count, input last,
		output ready);
endinterface

interface sha1md_out_if;
	import sha1md_pkg::*;

	logic  valid;
	logic  ready;
	word_t digest_h0;
	word_t digest_h1;
	word_t digest_h2;
	word_t digest_h3;
	word_t digest_h4;
	logic  too_long;

	modport source (output valid, output digest_h0, output digest_h1, output digest_h2,
		output digest_h3, output digest_h4, output too_long, input ready);
	modport sink (input valid, input digest_h0, input digest_h1, input digest_h2,
		input digest_h3, input digest_h4, input too_long, output ready);
endinterface

>>> design/sha1_message_digest_core.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// SHA-1 over a byte message delivered as big-endian 32-bit words.
//
// msg_in carries one item per message word: data_word, byte_count and last.
// Every item but the last holds four bytes; the last holds zero to four.
// digest_out carries one item per message: the five digest words and the
// too_long flag, set when the message held 2^29 bytes or more.
// An item that does not complete a 16-word block, and is not the last item,
// leaves msg_in.ready high for the next one. An item that completes a block
// holds msg_in.ready low while the single round unit runs 80 rounds, one per
// cycle, and then adds the block result into the chaining words.
// The last item adds one padding word per cycle, one or two more
// compressions, and a final step that loads the result register.
// The result register sits between the sides: a new message is taken while
// a digest waits; the core only stalls at the end of that next message until
// digest_out.ready takes the waiting item.
// Reset loads the initial chaining values and empties the block; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_message_digest_core (
	input  logic         clk,
	input  logic         arst_n,
	sha1md_in_if.sink    msg_in,
	sha1md_out_if.source digest_out
);
	import sha1md_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PAD   = 2'd1;
	localparam logic [1:0] ST_COMP  = 2'd2;
	localparam logic [1:0] ST_FINAL = 2'd3;

	localparam logic [6:0] LAST_ROUND = 7'd80;
	localparam logic [3:0] POS_LEN_HI = 4'd14;
	localparam logic [3:0] POS_END    = 4'd15;

	logic [1:0]  state_q;
	logic [3:0]  pos_q;
	logic [32:0] total_q;
	logic [6:0]  rnd_q;
	logic        finish_q;
	logic        pad80_q;
	logic        seen14_q;
	logic        lendone_q;
	word_t       win_q [16];
	word_t       a_q, b_q, c_q, d_q, e_q;
	word_t       chain_q [5];

	logic        out_valid_q;
	word_t       out_h_q [5];
	logic        out_long_q;

	logic        accept;
	byte_count_t count_c;
	byte_count_t add_n;
	logic [33:0] sum_c;
	logic [32:0] total_nx;
	word_t       first_word;
	word_t       pad_word;
	logic        push_en;
	word_t       push_word;
	logic        shift_en;
	word_t       shift_word;
	word_t       sched_word;
	word_t       f_c, k_c, tmp_c;
	logic        out_free;

	// Handshake on the input side, and whether the result register is free.
	assign msg_in.ready = (state_q == ST_IDLE);
	assign accept       = msg_in.valid && msg_in.ready;
	assign out_free     = !out_valid_q || digest_out.ready;

	// Byte count of the item, clamped on the last item and full otherwise; the total saturates.
	always_comb begin
		count_c = (msg_in.byte_count > FULL_COUNT) ? FULL_COUNT : msg_in.byte_count;
		add_n   = msg_in.last ? count_c : FULL_COUNT;
		sum_c   = {1'b0, total_q} + 34'(add_n);
		total_nx = sum_c[33] ? '1 : sum_c[32:0];
	end

	// First word pushed by a last item: kept bytes, then the pad marker if under four bytes.
	always_comb begin
		case (count_c)
			3'd0: first_word = {PAD_BYTE, 24'd0};
			3'd1: first_word = {msg_in.data_word[31:24], PAD_BYTE, 16'd0};
			3'd2: first_word = {msg_in.data_word[31:16], PAD_BYTE, 8'd0};
			3'd3: first_word = {msg_in.data_word[31:8], PAD_BYTE};
			default: first_word = msg_in.data_word;
		endcase
	end

	// Padding words: the marker after a full last word, zero fill, then the
	// bit length in the final slot once the fill has reached slot fourteen.
	always_comb begin
		if (pad80_q) begin
			pad_word = {PAD_BYTE, 24'd0};
		end else if (pos_q == POS_END && seen14_q) begin
			pad_word = {total_q[28:0], 3'b000};
		end else begin
			pad_word = '0;
		end
	end

	// Select what enters the block window this cycle.
	always_comb begin
		push_en   = accept || (state_q == ST_PAD);
		push_word = (state_q == ST_PAD) ? pad_word
			: (msg_in.last ? first_word : msg_in.data_word);
		sched_word = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		shift_en   = push_en || (state_q == ST_COMP && rnd_q != LAST_ROUND);
		shift_word = push_en ? push_word : {sched_word[30:0], sched_word[31]};
	end

	// Round function and round sum.
	always_comb begin
		if (rnd_q < 7'd20) begin
			f_c = d_q ^ (b_q & (c_q ^ d_q));
			k_c = K_ROUND0;
		end else if (rnd_q < 7'd40) begin
			f_c = b_q ^ c_q ^ d_q;
			k_c = K_ROUND1;
		end else if (rnd_q < 7'd60) begin
			f_c = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_c = K_ROUND2;
		end else begin
			f_c = b_q ^ c_q ^ d_q;
			k_c = K_ROUND3;
		end
		tmp_c = {a_q[26:0], a_q[31:27]} + f_c + e_q + k_c + win_q[0];
	end

	// Block window: message words shift in, then schedule words during rounds.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= shift_word;
		end
	end

	// Working variables of the round unit.
	always_ff @(posedge clk) begin
		if (push_en && pos_q == POS_END) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == ST_COMP && rnd_q != LAST_ROUND) begin
			a_q <= tmp_c;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Sequencer, counters and chaining words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			total_q   <= '0;
			rnd_q     <= '0;
			finish_q  <= 1'b0;
			pad80_q   <= 1'b0;
			seen14_q  <= 1'b0;
			lendone_q <= 1'b0;
			chain_q[0] <= INIT_H0;
			chain_q[1] <= INIT_H1;
			chain_q[2] <= INIT_H2;
			chain_q[3] <= INIT_H3;
			chain_q[4] <= INIT_H4;
		end else begin
			if (push_en) begin
				pos_q <= pos_q + 4'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						total_q <= total_nx;
						if (msg_in.last) begin
							finish_q <= 1'b1;
							pad80_q  <= (count_c == FULL_COUNT);
							seen14_q <= 1'b0;
						end
						if (pos_q == POS_END) begin
							state_q <= ST_COMP;
							rnd_q   <= '0;
						end else if (msg_in.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad80_q <= 1'b0;
					if (!pad80_q && pos_q == POS_LEN_HI) begin
						seen14_q <= 1'b1;
					end
					if (!pad80_q && pos_q == POS_END && seen14_q) begin
						lendone_q <= 1'b1;
					end
					if (pos_q == POS_END) begin
						state_q <= ST_COMP;
						rnd_q   <= '0;
					end
				end
				ST_COMP: begin
					if (rnd_q != LAST_ROUND) begin
						rnd_q <= rnd_q + 7'd1;
					end else begin
						chain_q[0] <= chain_q[0] + a_q;
						chain_q[1] <= chain_q[1] + b_q;
						chain_q[2] <= chain_q[2] + c_q;
						chain_q[3] <= chain_q[3] + d_q;
						chain_q[4] <= chain_q[4] + e_q;
						if (lendone_q) begin
							state_q <= ST_FINAL;
						end else if (finish_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						total_q    <= '0;
						finish_q   <= 1'b0;
						pad80_q    <= 1'b0;
						seen14_q   <= 1'b0;
						lendone_q  <= 1'b0;
						chain_q[0] <= INIT_H0;
						chain_q[1] <= INIT_H1;
						chain_q[2] <= INIT_H2;
						chain_q[3] <= INIT_H3;
						chain_q[4] <= INIT_H4;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register: loaded at the end of a message, held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINAL && out_free) begin
			out_valid_q <= 1'b1;
		end else if (digest_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINAL && out_free) begin
			for (int i = 0; i < 5; i++) begin
				out_h_q[i] <= chain_q[i];
			end
			out_long_q <= |total_q[32:29];
		end
	end

	assign digest_out.valid     = out_valid_q;
	assign digest_out.digest_h0 = out_h_q[0];
	assign digest_out.digest_h1 = out_h_q[1];
	assign digest_out.digest_h2 = out_h_q[2];
	assign digest_out.digest_h3 = out_h_q[3];
	assign digest_out.digest_h4 = out_h_q[4];
	assign digest_out.too_long  = out_long_q;

	// Checks on the sequencer.
	`ASSERT_IMP(a_comp_starts_on_block, clk, arst_n, state_q == ST_COMP && rnd_q == 7'd0, pos_q == 4'd0)
	`ASSERT_IMP(a_round_in_range, clk, arst_n, state_q == ST_COMP, rnd_q <= LAST_ROUND)
	`ASSERT_IMP(a_final_after_length, clk, arst_n, state_q == ST_FINAL, lendone_q && finish_q && pos_q == 4'd0)
	`ASSERT_NEXT(a_final_loads_result, clk, arst_n, state_q == ST_FINAL && out_free, digest_out.valid && state_q == ST_IDLE && total_q == 33'd0)
	`ASSERT_IMP(a_pad_only_when_closing, clk, arst_n, state_q == ST_PAD, finish_q && !lendone_q)

endmodule

>>> tb/sha1_message_digest_core_test.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_core_test
// Self-checking testbench of the SHA-1 digest core. Messages go in as
// big-endian words; a built-in SHA-1 predictor works out each digest when
// the closing item is taken, and a checker compares every digest item
// field by field in order. Directed messages cover the padding and
// byte-count corners. Random messages follow, with idle bursts on both
// channels and a quiet stretch at the end.
// ----------------------------------------------------------------------------
module sha1_message_digest_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1md_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 320;
	localparam int QUIET_ITEMS  = 100;
	localparam logic [32:0] BYTES_MAX  = 33'h1_FFFF_FFFF;
	localparam logic [32:0] LONG_BYTES = 33'h0_2000_0000;

	typedef struct {
		word_t h[5];
		logic  too_long;
	} digest_t;

	logic clk = 1'b0;
	logic arst_n;

	sha1md_in_if  msg_ch();
	sha1md_out_if digest_ch();

	sha1_message_digest_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_in     (msg_ch),
		.digest_out (digest_ch)
	);

	// Predictor state: chaining words, block buffer, fill and byte total.
	word_t       chain_state[5];
	word_t       block_buf[16];
	logic [3:0]  fill_pos;
	logic [32:0] msg_bytes;

	digest_t expected_digests[$];

	int  error_count = 0;
	int  words_sent = 0;
	int  messages_sent = 0;
	int  blocks_hashed = 0;
	int  digests_seen = 0;
	int  cycle_count = 0;
	int  stall_left = 0;
	bit  gaps_on = 1'b1;

	// Clock: 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d digests still due", cycle_count,
				expected_digests.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		$display("[%0t] ERROR: %s", $realtime, msg);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// SHA-1 predictor
	// ------------------------------------------------------------------
	function automatic word_t rotl(input word_t v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic void restart_message();
		chain_state[0] = INIT_H0;
		chain_state[1] = INIT_H1;
		chain_state[2] = INIT_H2;
		chain_state[3] = INIT_H3;
		chain_state[4] = INIT_H4;
		fill_pos = '0;
		msg_bytes = '0;
	endfunction

	// One 80-round compression of the full block into the chaining words.
	function automatic void hash_block();
		word_t sched[80];
		word_t a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			sched[r] = block_buf[r];
		for (int r = 16; r < 80; r++)
			sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
		a = chain_state[0];
		b = chain_state[1];
		c = chain_state[2];
		d = chain_state[3];
		e = chain_state[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = d ^ (b & (c ^ d));
				k = K_ROUND0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_ROUND1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_ROUND2;
			end else begin
				f = b ^ c ^ d;
				k = K_ROUND3;
			end
			t = rotl(a, 5) + f + e + k + sched[r];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain_state[0] += a;
		chain_state[1] += b;
		chain_state[2] += c;
		chain_state[3] += d;
		chain_state[4] += e;
		blocks_hashed++;
	endfunction

	function automatic void push_block_word(input word_t w);
		block_buf[fill_pos] = w;
		fill_pos = fill_pos + 4'd1;
		if (fill_pos == 4'd0)
			hash_block();
	endfunction

	// The byte total saturates instead of wrapping.
	function automatic void count_bytes(input int unsigned n);
		if ({1'b0, msg_bytes} + 34'(n) > {1'b0, BYTES_MAX})
			msg_bytes = BYTES_MAX;
		else
			msg_bytes = msg_bytes + 33'(n);
	endfunction

	// Updates the model with one taken item; the closing item queues a digest.
	function automatic void predict_item(input word_t data, input byte_count_t count,
		input logic is_last);
		byte_count_t used;
		int          shift;
		word_t       keep;
		digest_t     want;
		if (!is_last) begin
			push_block_word(data);
			count_bytes(4);
			return;
		end
		used = (count > FULL_COUNT) ? FULL_COUNT : count;
		count_bytes(used);
		if (used == FULL_COUNT) begin
			push_block_word(data);
			push_block_word({PAD_BYTE, 24'h0});
		end else begin
			shift = 8 * (4 - used);
			keep = (used == 0) ? '0 : ('1 << shift);
			push_block_word((data & keep) | (word_t'(PAD_BYTE) << (shift - 8)));
		end
		while (fill_pos != 4'd14)
			push_block_word('0);
		push_block_word('0);
		push_block_word(word_t'(msg_bytes << 3));
		for (int i = 0; i < 5; i++)
			want.h[i] = chain_state[i];
		want.too_long = (msg_bytes >= LONG_BYTES);
		expected_digests.push_back(want);
		messages_sent++;
		restart_message();
	endfunction

	// ------------------------------------------------------------------
	// Message side: sends one item, entered and left at a falling edge.
	// ------------------------------------------------------------------
	task automatic send_word(input word_t data, input byte_count_t count, input logic is_last);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			msg_ch.valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		msg_ch.valid = 1'b1;
		msg_ch.data_word = data;
		msg_ch.byte_count = count;
		msg_ch.last = is_last;
		do
			@(posedge clk);
		while (!msg_ch.ready);
		predict_item(data, count, is_last);
		words_sent++;
		@(negedge clk);
		msg_ch.valid = 1'b0;
	endtask

	// A message of full words with random content, closed by a last item.
	// Now and then a full word carries a junk count, which the core ignores.
	task automatic send_message(input int full_words);
		byte_count_t count;
		for (int i = 0; i < full_words; i++) begin
			count = ($urandom_range(0, 9) == 0) ? byte_count_t'($urandom_range(0, 7))
				: FULL_COUNT;
			send_word($urandom, count, 1'b0);
		end
		count = ($urandom_range(0, 9) == 0) ? byte_count_t'($urandom_range(5, 7))
			: byte_count_t'($urandom_range(0, 4));
		send_word($urandom, count, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// Digest side: random stall bursts on ready, and the result checker.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			digest_ch.ready = 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 8) - 1;
			digest_ch.ready = 1'b0;
		end else begin
			digest_ch.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		digest_t want;
		word_t   got[5];
		if (arst_n && digest_ch.valid && digest_ch.ready) begin
			digests_seen++;
			got[0] = digest_ch.digest_h0;
			got[1] = digest_ch.digest_h1;
			got[2] = digest_ch.digest_h2;
			got[3] = digest_ch.digest_h3;
			got[4] = digest_ch.digest_h4;
			if (expected_digests.size() == 0) begin
				report_error($sformatf("digest %0d arrived with none due, h0 %h",
					digests_seen, got[0]));
			end else begin
				want = expected_digests.pop_front();
				for (int i = 0; i < 5; i++)
					if (got[i] !== want.h[i])
						report_error($sformatf("digest %0d h%0d: got %h, want %h",
							digests_seen, i, got[i], want.h[i]));
				if (digest_ch.too_long !== want.too_long)
					report_error($sformatf("digest %0d too_long: got %b, want %b",
						digests_seen, digest_ch.too_long, want.too_long));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Short messages on the corners of the closing item.
	task automatic test_closing_counts();
		// Empty message.
		send_word('0, 3'd0, 1'b1);
		// Three bytes with junk in the unused byte, which must be cleared.
		send_word(32'h616263FF, 3'd3, 1'b1);
		send_word('1, 3'd1, 1'b1);
		send_word('1, 3'd2, 1'b1);
		send_word('0, FULL_COUNT, 1'b1);
		send_word('1, FULL_COUNT, 1'b1);
		// Counts above four on the closing item act as four.
		send_word(32'hDEADBEEF, 3'd5, 1'b1);
		send_word(32'h0123CDEF, 3'd6, 1'b1);
		send_word('1, 3'd7, 1'b1);
	endtask

	// Counts other than four on non-closing words are ignored.
	task automatic test_ignored_counts();
		send_word('1, 3'd0, 1'b0);
		send_word('0, 3'd1, 1'b0);
		send_word('1, 3'd2, 1'b0);
		send_word(32'hA5A5A5A5, 3'd3, 1'b0);
		send_word('1, 3'd5, 1'b0);
		send_word('0, 3'd6, 1'b0);
		send_word(32'h5A5A5A5A, 3'd7, 1'b0);
		send_word('1, FULL_COUNT, 1'b1);
	endtask

	// Lengths around the points where the pad or the length field spills into an extra block.
	task automatic test_block_boundaries();
		for (int n = 12; n <= 17; n++)
			send_message(n);
		send_message(31);
		send_message(32);
	endtask

	// Random messages, mostly short, a few spanning several blocks.
	task automatic test_random_messages(input int n_items);
		int stop_at;
		stop_at = words_sent + n_items;
		while (words_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0)
				send_message($urandom_range(30, 64));
			else
				send_message($urandom_range(0, 20));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.data_word = '0;
		msg_ch.byte_count = '0;
		msg_ch.last = 1'b0;
		digest_ch.ready = 1'b0;
		restart_message();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_closing_counts();
		test_ignored_counts();
		test_block_boundaries();
		test_random_messages(RANDOM_ITEMS);

		// Last stretch runs back to back on both sides.
		gaps_on = 1'b0;
		test_random_messages(QUIET_ITEMS);

		while (expected_digests.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);

		$display("Sent %0d words in %0d messages, %0d blocks compressed.", words_sent,
			messages_sent, blocks_hashed);
		$display("Checked %0d digests, %0d errors, in %0d cycles.", digests_seen,
			error_count, cycle_count);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/sha1md_pkg.sv
design/sha1md_ifs.sv
design/sha1_message_digest_core.sv
tb/sha1_message_digest_core_test.sv
